// File: design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define FPR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be seen at a clock edge out of reset
`define FPR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/fpr_pkg.sv
package fpr_pkg;

	localparam int MAX_LEN    = 16;
	localparam int ADDR_W     = $clog2(MAX_LEN);
	localparam int FILL_W     = $clog2(MAX_LEN + 1);
	localparam int LEN_W      = 5;
	localparam int IDX_W      = 4;
	localparam int JOBQ_DEPTH = 2;

	localparam logic [7:0] START_BYTE = 8'hAA;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;
	localparam logic [1:0] ST_TMO  = 2'd3;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       command;
		logic [LEN_W-1:0] frame_len;
	} job_t;

endpackage

// File: design/fpr_ram.sv
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/fpr_front.sv
module fpr_front
	import fpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       now_ms,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	output logic              job_valid,
	input  logic              job_ready,
	output job_t              job,
	input  logic              run_done,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [7:0]        ram_wdata
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_CMD   = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;

	logic [2:0]        phase_q, phase_d;
	logic [7:0]        cmd_q, cmd_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [7:0]        chk_q, chk_d;
	logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
	logic [31:0]       stamp_q, stamp_d;
	logic [31:0]       limit_q;
	logic              busy_q;
	logic [31:0]       gap;
	logic              tmo;
	logic              acc;
	logic              wr;

	assign cfg_ready = 1'b1;
	assign s_tready  = job_ready && !(phase_q == PH_DATA && busy_q);
	assign acc       = s_tvalid && s_tready;
	assign job_valid = acc;
	assign gap       = now_ms - stamp_q;
	assign tmo       = (limit_q != '0) && (phase_q != PH_HUNT) && (gap > limit_q);
	assign fill_inc  = fill_q + FILL_W'(1);

	always_comb begin
		phase_d       = phase_q;
		cmd_d         = cmd_q;
		len_d         = len_q;
		chk_d         = chk_q;
		fill_d        = fill_q;
		stamp_d       = stamp_q;
		job.status    = ST_IDLE;
		job.command   = '0;
		job.frame_len = '0;
		wr            = 1'b0;
		if (tmo) begin
			job.status = ST_TMO;
			chk_d      = '0;
			fill_d     = '0;
			if (rx_byte == START_BYTE) begin
				phase_d = PH_CMD;
				stamp_d = now_ms;
			end else begin
				phase_d = PH_HUNT;
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						phase_d = PH_CMD;
						stamp_d = now_ms;
					end
				end
				PH_CMD: begin
					cmd_d   = rx_byte;
					chk_d   = rx_byte;
					phase_d = PH_LEN;
					stamp_d = now_ms;
				end
				PH_LEN: begin
					len_d = rx_byte[LEN_W-1:0];
					if (rx_byte > 8'(MAX_LEN)) begin
						job.status = ST_ERR;
						phase_d    = PH_HUNT;
						chk_d      = '0;
						fill_d     = '0;
					end else begin
						chk_d   = chk_q ^ rx_byte;
						fill_d  = '0;
						phase_d = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
						stamp_d = now_ms;
					end
				end
				PH_DATA: begin
					wr      = fill_q < FILL_W'(MAX_LEN);
					fill_d  = fill_inc;
					chk_d   = chk_q ^ rx_byte;
					stamp_d = now_ms;
					if (LEN_W'(fill_inc) >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					stamp_d = now_ms;
					phase_d = PH_HUNT;
					chk_d   = '0;
					fill_d  = '0;
					if (rx_byte == chk_q) begin
						job.status    = ST_OK;
						job.command   = cmd_q;
						job.frame_len = len_q;
					end else begin
						job.status = ST_ERR;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					chk_d   = '0;
					fill_d  = '0;
				end
			endcase
		end
	end

	assign ram_we    = acc && wr;
	assign ram_waddr = fill_q[ADDR_W-1:0];
	assign ram_wdata = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cmd_q   <= '0;
			len_q   <= '0;
			chk_q   <= '0;
			fill_q  <= '0;
			stamp_q <= '0;
			limit_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (acc) begin
				phase_q <= phase_d;
				cmd_q   <= cmd_d;
				len_q   <= len_d;
				chk_q   <= chk_d;
				fill_q  <= fill_d;
				stamp_q <= stamp_d;
			end
			if (acc && job.status == ST_OK && job.frame_len != '0) begin
				busy_q <= 1'b1;
			end else if (run_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/fpr_jobq.sv
module fpr_jobq
	import fpr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop,
	output job_t pop_job
);

	localparam int PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
	localparam int CW = $clog2(JOBQ_DEPTH + 1);

	job_t          slot_q [JOBQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = cnt_q != CW'(JOBQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = slot_q[rp_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(JOBQ_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(JOBQ_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: design/fpr_back.sv
module fpr_back
	import fpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_pop,
	input  job_t              job,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata,
	output logic              run_done,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [1:0]        status,
	output logic [7:0]        command,
	output logic [LEN_W-1:0]  frame_len,
	output logic [7:0]        data_byte,
	output logic [IDX_W-1:0]  byte_index,
	output logic              has_data,
	output logic              last
);

`include "assert_macros.svh"

	logic              run_q;
	logic [7:0]        cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  rd_idx_q;
	logic              pend_q;
	logic [IDX_W-1:0]  dix_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [7:0]        command_q;
	logic [LEN_W-1:0]  frame_len_q;
	logic [7:0]        data_q;
	logic [IDX_W-1:0]  index_q;
	logic              has_q;
	logic              last_q;
	logic              out_free;
	logic              start_run;
	logic              single;
	logic              issue;
	logic              emit;
	logic              emit_last;

	assign out_free  = !out_valid_q || m_tready;
	assign job_pop   = !run_q && job_valid && out_free;
	assign start_run = job_pop && job.status == ST_OK && job.frame_len != '0;
	assign single    = job_pop && !start_run;
	assign issue     = run_q && (rd_idx_q < len_q) && (!pend_q || out_free);
	assign emit      = run_q && pend_q && out_free;
	assign emit_last = emit && (LEN_W'(dix_q) + LEN_W'(1) == len_q);
	assign run_done  = emit_last;

	assign ram_re    = issue;
	assign ram_raddr = rd_idx_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_run) begin
				run_q    <= 1'b1;
				rd_idx_q <= '0;
				pend_q   <= 1'b0;
			end else begin
				if (emit_last) begin
					run_q <= 1'b0;
				end
				if (issue) begin
					rd_idx_q <= rd_idx_q + LEN_W'(1);
					pend_q   <= 1'b1;
				end else if (emit) begin
					pend_q <= 1'b0;
				end
			end
			if (single || emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_run) begin
			cmd_q <= job.command;
			len_q <= job.frame_len;
		end
		if (issue) begin
			dix_q <= rd_idx_q[IDX_W-1:0];
		end
		if (single) begin
			status_q    <= job.status;
			command_q   <= job.command;
			frame_len_q <= job.frame_len;
			data_q      <= '0;
			index_q     <= '0;
			has_q       <= 1'b0;
			last_q      <= 1'b1;
		end else if (emit) begin
			status_q    <= ST_OK;
			command_q   <= cmd_q;
			frame_len_q <= len_q;
			data_q      <= ram_rdata;
			index_q     <= dix_q;
			has_q       <= 1'b1;
			last_q      <= emit_last;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign status     = status_q;
	assign command    = command_q;
	assign frame_len  = frame_len_q;
	assign data_byte  = data_q;
	assign byte_index = index_q;
	assign has_data   = has_q;
	assign last       = last_q;

	`FPR_ASSERT(a_done_ends_run, clk, arst_n, run_done |=> !run_q, "run still active after done")
	`FPR_ASSERT(a_idx_in_range, clk, arst_n, run_q |-> (rd_idx_q <= len_q), "read index past length")
	`FPR_NEVER(a_pend_no_read, clk, arst_n, run_q && pend_q && rd_idx_q == '0, "pending data never read")

endmodule

// File: design/framed_packet_receiver_xor_checksum.sv
// Status words pass through the job queue and the output register; a good frame's
//   payload words follow its checksum byte, 1 word per cycle while m_tready is high.
// Throughput: 1 byte per cycle while the job queue has room; payload bytes of the next
//   frame wait until the previous frame's run (up to 16 RAM words) has drained.
// Reset: parser returns to start-byte hunt, timeout_limit and stamps clear, queues empty;
//   the payload RAM is not cleared.
module framed_packet_receiver_xor_checksum
	import fpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // rx_byte[7:0], now_ms[39:8]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // command[7:0], frame_len[12:8], data_byte[20:13],
	                               // byte_index[24:21], zero[31:25]
	output logic [2:0]  m_tuser,   // status[1:0], has_data[2]
	output logic        m_tlast
);

	logic              push, push_ready, pop_valid, pop;
	job_t              push_job, pop_job;
	logic              run_done;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic [1:0]        status;
	logic [7:0]        command;
	logic [LEN_W-1:0]  frame_len;
	logic [7:0]        data_byte;
	logic [IDX_W-1:0]  byte_index;
	logic              has_data;

	fpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.rx_byte   (s_tdata[7:0]),
		.now_ms    (s_tdata[39:8]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.job_valid (push),
		.job_ready (push_ready),
		.job       (push_job),
		.run_done  (run_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	fpr_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_job    (pop_job)
	);

	fpr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LEN)
	) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job_pop    (pop),
		.job        (pop_job),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.run_done   (run_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.status     (status),
		.command    (command),
		.frame_len  (frame_len),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.has_data   (has_data),
		.last       (m_tlast)
	);

	assign m_tdata = {7'd0, byte_index, data_byte, frame_len, command};
	assign m_tuser = {has_data, status};

endmodule

// File: test/frame_result_checker.sv
module frame_result_checker
	import fpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // rx_byte[7:0], now_ms[39:8]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // command[7:0], frame_len[12:8], data_byte[20:13],
	                               // byte_index[24:21], zero[31:25]
	input  logic [2:0]  m_tuser,   // status[1:0], has_data[2]
	input  logic        m_tlast,
	output int          fail_count,
	output int          outstanding,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {HUNT, GET_CMD, GET_LEN, GET_DATA, GET_SUM} parse_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       command;
		logic [LEN_W-1:0] frame_len;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             has_data;
		logic             last;
	} result_t;

	parse_t           phase;
	logic [7:0]       cmd_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       payload [MAX_LEN];
	logic [7:0]       xsum;
	logic [LEN_W-1:0] fill;
	logic [31:0]      stamp;
	logic [31:0]      gap_limit;
	result_t          expected_words [$];
	int               n_fail;
	int               n_words;

	assign fail_count    = n_fail;
	assign words_checked = n_words;

	function automatic result_t make_word(logic [1:0] st, logic [7:0] c, logic [LEN_W-1:0] l,
	                                      logic [7:0] d, logic [IDX_W-1:0] i, logic h,
	                                      logic lst);
		return {st, c, l, d, i, h, lst};
	endfunction

	task automatic restart_hunt();
		phase = HUNT;
		fill  = '0;
		xsum  = '0;
	endtask

	task automatic take_byte(input logic [7:0] b, input logic [31:0] t);
		logic [31:0] since;
		since = t - stamp;
		// timeout check comes first; the same byte is then seen from the hunt
		if (gap_limit != 0 && phase != HUNT && since > gap_limit) begin
			restart_hunt();
			if (b == START_BYTE) begin
				phase = GET_CMD;
				stamp = t;
			end
			expected_words.push_back(make_word(ST_TMO, '0, '0, '0, '0, 1'b0, 1'b1));
			return;
		end
		case (phase)
			HUNT: begin
				if (b == START_BYTE) begin
					phase = GET_CMD;
					stamp = t;
				end
			end
			GET_CMD: begin
				cmd_q = b;
				xsum  = b;
				phase = GET_LEN;
				stamp = t;
			end
			GET_LEN: begin
				if (b > MAX_LEN) begin
					restart_hunt();
					expected_words.push_back(make_word(ST_ERR, '0, '0, '0, '0, 1'b0, 1'b1));
					return;
				end
				len_q = b[LEN_W-1:0];
				xsum  = xsum ^ b;
				fill  = '0;
				phase = (b == 0) ? GET_SUM : GET_DATA;
				stamp = t;
			end
			GET_DATA: begin
				if (fill < MAX_LEN)
					payload[fill[ADDR_W-1:0]] = b;
				fill  = fill + 1'b1;
				xsum  = xsum ^ b;
				if (fill >= len_q)
					phase = GET_SUM;
				stamp = t;
			end
			GET_SUM: begin
				stamp = t;
				if (b == xsum) begin
					if (len_q == 0) begin
						expected_words.push_back(make_word(ST_OK, cmd_q, '0, '0, '0, 1'b0,
						                                   1'b1));
					end else begin
						for (int i = 0; i < len_q; i++)
							expected_words.push_back(make_word(ST_OK, cmd_q, len_q, payload[i],
							                                   i[IDX_W-1:0], 1'b1,
							                                   i == len_q - 1));
					end
					restart_hunt();
					return;
				end
				restart_hunt();
				expected_words.push_back(make_word(ST_ERR, '0, '0, '0, '0, 1'b0, 1'b1));
				return;
			end
			default: restart_hunt();
		endcase
		expected_words.push_back(make_word(ST_IDLE, '0, '0, '0, '0, 1'b0, 1'b1));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			restart_hunt();
			cmd_q     = '0;
			len_q     = '0;
			stamp     = '0;
			gap_limit = '0;
			expected_words.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[1:0], m_tdata[7:0], m_tdata[12:8], m_tdata[20:13],
				       m_tdata[24:21], m_tuser[2], m_tlast};
				n_words++;
				if (expected_words.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("word %0d unexpected: status %0d cmd %02h len %0d data %02h idx %0d has %0b last %0b",
						         n_words, got.status, got.command, got.frame_len,
						         got.data_byte, got.byte_index, got.has_data, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						n_fail++;
						if (n_fail <= 10) begin
							$display("word %0d expected: status %0d cmd %02h len %0d data %02h idx %0d has %0b last %0b",
							         n_words, want.status, want.command, want.frame_len,
							         want.data_byte, want.byte_index, want.has_data, want.last);
							$display("word %0d actual:   status %0d cmd %02h len %0d data %02h idx %0d has %0b last %0b",
							         n_words, got.status, got.command, got.frame_len,
							         got.data_byte, got.byte_index, got.has_data, got.last);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				gap_limit = cfg_data;
			if (s_tvalid && s_tready)
				take_byte(s_tdata[7:0], s_tdata[39:8]);
		end
		outstanding <= expected_words.size();
	end

endmodule

// File: test/tb_framed_packet_receiver_xor_checksum.sv
module tb_framed_packet_receiver_xor_checksum;
	timeunit 1ns;
	timeprecision 1ps;
	import fpr_pkg::*;

	localparam int CYCLE_LIMIT  = 500_000;
	localparam int PHASE_BYTES  = 62;
	localparam int LONG_HOLD    = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // rx_byte[7:0], now_ms[39:8]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // command[7:0], frame_len[12:8], data_byte[20:13],
	                               // byte_index[24:21], zero[31:25]
	logic [2:0]  m_tuser;          // status[1:0], has_data[2]
	logic        m_tlast;

	int          fails;
	int          outstanding;
	int          words_checked;

	logic [31:0] clock_ms;
	logic [31:0] limit_now;
	int          burst_left;
	int          n_bytes;
	int          n_intact;
	int          n_broken;
	int          n_settings;
	bit          hold_req  = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left;
	int          rx_cycle;
	int          rx_mode;
	int          cyc_count;

	framed_packet_receiver_xor_checksum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	frame_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fails),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (cyc_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: changing stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			rx_mode <= $urandom_range(0, 3);
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 1) == 1);
				2:       m_tready <= (rx_cycle % 4 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	function automatic logic [31:0] pick_gap();
		case ($urandom_range(0, 39))
			0:       return $urandom;
			1:       return (limit_now == '1) ? limit_now : limit_now + 1;
			2:       return limit_now;
			default: return $urandom_range(0, (limit_now == 0 || limit_now > 12) ? 12 : limit_now);
		endcase
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 11))
			0:       return 0;
			1, 2:    return MAX_LEN;
			default: return $urandom_range(1, MAX_LEN - 1);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [31:0] dt);
		int gap;
		clock_ms = clock_ms + dt;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {clock_ms, b};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		n_bytes++;
	endtask

	task automatic send_frame(input logic [7:0] cmd, input int len, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] d;
		send_byte(START_BYTE, pick_gap());
		send_byte(cmd, pick_gap());
		send_byte(8'(len), pick_gap());
		sum = cmd ^ 8'(len);
		repeat (len) begin
			d = 8'($urandom);
			sum = sum ^ d;
			send_byte(d, pick_gap());
		end
		if (corrupt)
			sum = sum ^ 8'(1 << $urandom_range(0, 7));
		send_byte(sum, pick_gap());
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limit(input logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = v;
		n_settings++;
	endtask

	initial begin
		logic [31:0] limits [5];
		int          r;
		int          len;
		clock_ms   = 32'hFFFF_FFEC;
		limit_now  = '0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, timeout off
		set_limit(32'd0);
		send_byte(8'h00, 1);
		send_byte(START_BYTE, 1);
		send_byte(8'hFF, 1);
		send_byte(8'h00, 1);
		send_byte(8'hFF, 1);
		send_byte(START_BYTE, 1);
		send_byte(8'h00, 1);
		send_byte(8'hFF, 1);
		send_byte(START_BYTE, 1);
		send_byte(8'h12, 1);
		send_byte(8'd17, 1);
		send_byte(START_BYTE, 1);
		send_byte(8'h5A, 1);
		send_byte(8'h02, 1);
		send_byte(8'h11, 1);
		send_byte(8'h22, 1);
		send_byte(8'h5A ^ 8'h02 ^ 8'h11 ^ 8'h22 ^ 8'h01, 1);

		// directed timeout cases, crossing the ms wrap
		set_limit(32'd3);
		send_byte(START_BYTE, 1);
		send_byte(8'h01, 3);
		send_byte(8'h00, 4);
		send_byte(START_BYTE, 1);
		send_byte(8'h33, 1);
		send_byte(START_BYTE, 100);
		send_byte(8'h07, 1);
		send_byte(8'h00, 2);
		send_byte(8'h07, 3);

		limits = '{32'hFFFF_FFFF, $urandom, 32'd20, 32'd1, 32'd0};
		foreach (limits[p]) begin
			set_limit(limits[p]);
			if (p == 2)
				hold_req <= 1'b1;
			if (p == 3)
				drain();
			len = n_bytes + PHASE_BYTES;
			while (n_bytes < len) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					send_frame(8'($urandom), pick_len(), r >= 60);
					if (r < 60)
						n_intact++;
					else
						n_broken++;
				end else if (r < 76) begin
					send_byte(START_BYTE, pick_gap());
					send_byte(8'($urandom), pick_gap());
					send_byte($urandom_range(0, 1) ? 8'd17 : 8'($urandom_range(17, 255)),
					          pick_gap());
					n_broken++;
				end else if (r < 86) begin
					r = $urandom_range(1, MAX_LEN);
					send_byte(START_BYTE, pick_gap());
					send_byte(8'($urandom), pick_gap());
					send_byte(8'(r), pick_gap());
					repeat ($urandom_range(0, r - 1))
						send_byte(8'($urandom), pick_gap());
					n_broken++;
				end else begin
					repeat ($urandom_range(1, 4))
						send_byte(($urandom_range(0, 3) == 0) ? START_BYTE : 8'($urandom),
						          pick_gap());
				end
			end
		end

		drain();
		$display("Sent %0d bytes: %0d intact frames, %0d corrupt or cut short, plus noise,",
		         n_bytes, n_intact, n_broken);
		$display("over %0d timeout settings; %0d result words checked, %0d mismatched.",
		         n_settings, words_checked, fails);
		if (fails == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
